// ===== hdl/sge_pkg.sv =====
`timescale 1ns / 1ps

package sge_pkg;

    // event kinds carried by the opcode field
    typedef enum logic [1:0] {
        OP_CS_EDGE  = 2'd0,
        OP_SPI_BYTE = 2'd1,
        OP_PIN_CHG  = 2'd2,
        OP_NONE     = 2'd3
    } t_opcode;

    // position within a transaction
    typedef enum logic [1:0] {
        PH_ADDR = 2'd0,
        PH_REG  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_out;
        logic take_addr;
        logic take_ptr;
        logic data_xfer;
        logic pin_evt;
    } t_cmd;

    localparam int REG_COUNT = 11;

    localparam logic [7:0] REG_DIR     = 8'd0;
    localparam logic [7:0] REG_POL     = 8'd1;
    localparam logic [7:0] REG_EN      = 8'd2;
    localparam logic [7:0] REG_COMPARE = 8'd3;
    localparam logic [7:0] REG_INT_CFG = 8'd4;
    localparam logic [7:0] REG_CTRL    = 8'd5;
    localparam logic [7:0] REG_PULLUP  = 8'd6;
    localparam logic [7:0] REG_FLAG    = 8'd7;
    localparam logic [7:0] REG_CAP     = 8'd8;
    localparam logic [7:0] REG_PORT    = 8'd9;
    localparam logic [7:0] REG_LATCH   = 8'd10;

    localparam logic [7:0] DIR_RESET  = 8'hFF;
    localparam int         CTRL_POL_BIT = 1;
    localparam int         READ_BIT     = 0;

endpackage

// ===== hdl/sge_ctrl.sv =====
`timescale 1ns / 1ps

module sge_ctrl
    import sge_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_cmd       o_cmd
);

    t_phase r_phase, n_phase;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ADDR;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (w_accept) begin
            o_cmd.load_out = 1'b1;
            n_out_valid    = 1'b1;
            case (t_opcode'(i_opcode))
                OP_CS_EDGE: begin
                    n_phase = PH_ADDR;
                end
                OP_SPI_BYTE: begin
                    case (r_phase)
                        PH_ADDR: begin
                            o_cmd.take_addr = 1'b1;
                            n_phase         = PH_REG;
                        end
                        PH_REG: begin
                            o_cmd.take_ptr = 1'b1;
                            n_phase        = PH_DATA;
                        end
                        PH_DATA: begin
                            o_cmd.data_xfer = 1'b1;
                        end
                        default: begin
                            n_phase = PH_ADDR;
                        end
                    endcase
                end
                OP_PIN_CHG: begin
                    o_cmd.pin_evt = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

`ifndef SYNTHESIS
    // a held result blocks new transfers
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result is held");

    // every accepted transfer yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted transfer gave no result");

    // at most one datapath action per transfer
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.take_addr, o_cmd.take_ptr, o_cmd.data_xfer, o_cmd.pin_evt}))
        else $error("more than one datapath action");

    // the register byte always moves the transaction into the data phase
    a_ptr_to_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_ptr |=> (r_phase == PH_DATA))
        else $error("phase did not advance after register byte");
`endif

endmodule

// ===== hdl/sge_datapath.sv =====
`timescale 1ns / 1ps

module sge_datapath
    import sge_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_spi_byte,
    input  logic [2:0] i_pin_index,
    input  logic       i_pin_level,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    output logic [7:0] o_miso_byte,
    output logic       o_int_line
);

    logic [1:0] r_chip_addr;
    logic       r_selected, n_selected;
    logic       r_read_mode, n_read_mode;
    logic [7:0] r_ptr, n_ptr;
    logic [7:0] r_pins, n_pins;
    logic [7:0] r_dir, n_dir;
    logic [7:0] r_pol, n_pol;
    logic [7:0] r_en, n_en;
    logic [7:0] r_compare, n_compare;
    logic [7:0] r_int_cfg, n_int_cfg;
    logic [7:0] r_ctrl, n_ctrl;
    logic [7:0] r_pullup, n_pullup;
    logic [7:0] r_flag, n_flag;
    logic [7:0] r_cap, n_cap;
    logic [7:0] r_latch, n_latch;
    logic [7:0] r_miso, n_miso;
    logic       r_int, n_int;

    logic [7:0] w_port_now;
    logic [7:0] w_port_after;
    logic [7:0] w_pins_after;
    logic [7:0] w_mask;
    logic [7:0] w_read_data;

    assign w_port_now   = ((r_pins ^ r_pol) & r_dir) | (r_latch & ~r_dir);
    assign w_mask       = 8'd1 << i_pin_index;
    assign w_pins_after = i_pin_level ? (r_pins | w_mask) : (r_pins & ~w_mask);
    assign w_port_after = ((w_pins_after ^ r_pol) & r_dir) | (r_latch & ~r_dir);

    always_comb begin
        case (r_ptr)
            REG_DIR:     w_read_data = r_dir;
            REG_POL:     w_read_data = r_pol;
            REG_EN:      w_read_data = r_en;
            REG_COMPARE: w_read_data = r_compare;
            REG_INT_CFG: w_read_data = r_int_cfg;
            REG_CTRL:    w_read_data = r_ctrl;
            REG_PULLUP:  w_read_data = r_pullup;
            REG_FLAG:    w_read_data = r_flag;
            REG_CAP:     w_read_data = r_cap;
            REG_PORT:    w_read_data = w_port_now;
            REG_LATCH:   w_read_data = r_latch;
            default:     w_read_data = 8'd0;
        endcase
    end

    always_comb begin
        n_selected  = r_selected;
        n_read_mode = r_read_mode;
        n_ptr       = r_ptr;
        n_pins      = r_pins;
        n_dir       = r_dir;
        n_pol       = r_pol;
        n_en        = r_en;
        n_compare   = r_compare;
        n_int_cfg   = r_int_cfg;
        n_ctrl      = r_ctrl;
        n_pullup    = r_pullup;
        n_flag      = r_flag;
        n_cap       = r_cap;
        n_latch     = r_latch;
        n_miso      = 8'd0;

        if (i_cmd.take_addr) begin
            n_selected  = (i_spi_byte[2:1] == r_chip_addr);
            n_read_mode = i_spi_byte[READ_BIT];
        end
        if (i_cmd.take_ptr) begin
            n_ptr = i_spi_byte;
        end
        if (i_cmd.data_xfer && r_selected) begin
            if (r_read_mode) begin
                n_miso = w_read_data;
                // reading port or capture acknowledges the interrupt
                if (r_ptr == REG_PORT || r_ptr == REG_CAP) begin
                    n_flag = 8'd0;
                end
            end else begin
                case (r_ptr)
                    REG_DIR:     n_dir     = i_spi_byte;
                    REG_POL:     n_pol     = i_spi_byte;
                    REG_EN:      n_en      = i_spi_byte;
                    REG_COMPARE: n_compare = i_spi_byte;
                    REG_INT_CFG: n_int_cfg = i_spi_byte;
                    REG_CTRL:    n_ctrl    = i_spi_byte;
                    REG_PULLUP:  n_pullup  = i_spi_byte;
                    REG_PORT:    n_latch   = i_spi_byte;
                    REG_LATCH:   n_latch   = i_spi_byte;
                    default: begin
                    end
                endcase
            end
        end
        if (i_cmd.pin_evt) begin
            n_pins = w_pins_after;
            if (((w_port_now ^ w_port_after) & w_mask & r_en) != 8'd0) begin
                n_flag = r_flag | w_mask;
                n_cap  = w_port_after;
            end
        end

        // active-high when the control bit is set, otherwise active-low
        n_int = (n_flag != 8'd0) ^ ~n_ctrl[CTRL_POL_BIT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_addr <= 2'd0;
            r_selected  <= 1'b0;
            r_read_mode <= 1'b0;
            r_ptr       <= 8'd0;
            r_pins      <= 8'd0;
            r_dir       <= DIR_RESET;
            r_pol       <= 8'd0;
            r_en        <= 8'd0;
            r_compare   <= 8'd0;
            r_int_cfg   <= 8'd0;
            r_ctrl      <= 8'd0;
            r_pullup    <= 8'd0;
            r_flag      <= 8'd0;
            r_cap       <= 8'd0;
            r_latch     <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_chip_addr <= i_cfg_wdata;
            end
            if (i_cmd.load_out) begin
                r_selected  <= n_selected;
                r_read_mode <= n_read_mode;
                r_ptr       <= n_ptr;
                r_pins      <= n_pins;
                r_dir       <= n_dir;
                r_pol       <= n_pol;
                r_en        <= n_en;
                r_compare   <= n_compare;
                r_int_cfg   <= n_int_cfg;
                r_ctrl      <= n_ctrl;
                r_pullup    <= n_pullup;
                r_flag      <= n_flag;
                r_cap       <= n_cap;
                r_latch     <= n_latch;
            end
        end
    end

    // result register, held until the transfer on the output side
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_miso <= n_miso;
            r_int  <= n_int;
        end
    end

    assign o_miso_byte = r_miso;
    assign o_int_line  = r_int;

endmodule

// ===== hdl/spi_gpio_expander_core.sv =====
`timescale 1ns / 1ps

// Eight-pin SPI I/O expander driven by one event per input transfer: a
// chip-select edge, an SPI byte or a pin level change. Each event produces
// exactly one result (returned MISO byte and interrupt pin level) in an
// output register in the cycle after the input transfer. The block takes
// one event per clock; it accepts a new event whenever the output register
// is empty or is being emptied in the same cycle, so only back-pressure on
// the output side slows it. The user must write the chip address through
// i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.

module spi_gpio_expander_core
    import sge_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_spi_byte,
    input  logic [2:0] i_pin_index,
    input  logic       i_pin_level,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_miso_byte,
    output logic       o_int_line
);

    t_cmd w_cmd;

    sge_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    sge_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_spi_byte  (i_spi_byte),
        .i_pin_index (i_pin_index),
        .i_pin_level (i_pin_level),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_miso_byte (o_miso_byte),
        .o_int_line  (o_int_line)
    );

endmodule
